[rtl/core/ctc_greedy_decode_confidence_macros.svh]
// assertion helpers for the ctc greedy decoder
`ifndef CTC_GREEDY_DECODE_CONFIDENCE_MACROS_SVH
`define CTC_GREEDY_DECODE_CONFIDENCE_MACROS_SVH

`ifndef SYNTHESIS
`define CTCGD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctcgd assertion failed");
`define CTCGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctcgd assertion failed");
`else
`define CTCGD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CTCGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/ctcgd_pkg.sv]
package ctcgd_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int MAX_STEPS   = 256;

    localparam int LOGIT_W = 16;
    localparam int CLASS_W = 7;
    localparam int PROB_W  = 16;
    localparam int TOTAL_W = 9;
    localparam int SUM_W   = 25;
    localparam int CC_W    = $clog2(MAX_CLASSES);
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);

    // exp() unit: 12 exponent bits, two multiplier passes per bit
    localparam int EXP_BITS  = 12;
    localparam int EXP_ITERS = 2 * EXP_BITS;
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

    // mean divider: one quotient bit per cycle
    localparam int DIV_W     = SUM_W + 1;
    localparam int DIV_ITERS = DIV_W;

    localparam int ITER_W = 5;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};
    localparam logic [PROB_W-1:0]  PROB_MAX  = {PROB_W{1'b1}};

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              accept;
        logic              eval;
        logic              exp_step;
        logic              emit_char;
        logic              div_init;
        logic              div_step;
        logic              emit_sum;
        logic              seq_end;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic char_hit;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/ctc_greedy_decode_confidence.sv]
// a class that does not end a step is taken in the idle state, which stays ready for the next class
// step end: an evaluation state, then for a character the exp iteration (shared 32x32 multiplier) and an emit
// sequence end: a further divider init and the bit-serial mean divider, then an emit for the summary
// results leave through a one-entry output register; a full register stalls only the emit states
// reset: synchronous active-low, clears sequence state, charset size returns to 127
module ctc_greedy_decode_confidence import ctcgd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: charset size
    input  logic                      i_cfg_we,
    input  logic [CLASS_W-1:0]        i_cfg_data,
    // logit items
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_last_in_step,
    input  logic                      i_last_step,
    // result items
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_kind,
    output logic [CLASS_W-1:0]        o_char_position,
    output logic [PROB_W-1:0]         o_mean_confidence,
    output logic [TOTAL_W-1:0]        o_char_total,
    output logic                      o_last
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: item intake, exp iteration, divide and emit ordering
    ctcgd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_last_in_step (i_last_in_step),
        .i_last_step    (i_last_step),
        .i_sts          (sts),
        .o_ready        (o_ready),
        .o_cmd          (cmd)
    );

    // datapath: running argmax, sequence totals, exp unit, divider, output register
    ctcgd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_logit           (i_logit),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_char_position   (o_char_position),
        .o_mean_confidence (o_mean_confidence),
        .o_char_total      (o_char_total),
        .o_last            (o_last)
    );

endmodule

[rtl/core/ctcgd_ctrl.sv]
`include "ctc_greedy_decode_confidence_macros.svh"

module ctcgd_ctrl import ctcgd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last_in_step,
    input  logic i_last_step,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EVAL      = 3'd1;
    localparam logic [2:0] S_EXP       = 3'd2;
    localparam logic [2:0] S_EMIT_CHAR = 3'd3;
    localparam logic [2:0] S_DIV_INIT  = 3'd4;
    localparam logic [2:0] S_DIV       = 3'd5;
    localparam logic [2:0] S_EMIT_SUM  = 3'd6;

    localparam logic [ITER_W-1:0] EXP_LAST = ITER_W'(EXP_ITERS - 1);
    localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(DIV_ITERS - 1);

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_seq_end, n_seq_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_seq_end <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_seq_end <= n_seq_end;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_seq_end = r_seq_end;
        o_ready   = 1'b0;
        o_cmd     = '0;
        o_cmd.seq_end = r_seq_end;
        o_cmd.iter    = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_last_in_step) begin
                    n_state   = S_EVAL;
                    n_seq_end = i_last_step;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_cnt      = '0;
                if (i_sts.char_hit) begin
                    n_state = S_EXP;
                end else if (r_seq_end) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (r_cnt == EXP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_EMIT_CHAR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT_CHAR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    n_state = r_seq_end ? S_DIV_INIT : S_IDLE;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_EMIT_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT_SUM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // results are only loaded into a free output register
    `CTCGD_ASSERT_SAME(a_load_free, i_clk, i_rst_n, o_cmd.emit_char || o_cmd.emit_sum, i_sts.out_free)
    // only one datapath operation per cycle
    `CTCGD_ASSERT_SAME(a_one_op, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.accept, o_cmd.eval, o_cmd.exp_step, o_cmd.emit_char, o_cmd.div_init, o_cmd.div_step, o_cmd.emit_sum}))
    // the exp iteration always ends in the character emit
    `CTCGD_ASSERT_NEXT(a_exp_done, i_clk, i_rst_n, r_state == S_EXP && r_cnt == EXP_LAST, r_state == S_EMIT_CHAR)

endmodule

[rtl/core/ctcgd_dp.sv]
module ctcgd_dp import ctcgd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_we,
    input  logic [CLASS_W-1:0]        i_cfg_data,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic                      o_kind,
    output logic [CLASS_W-1:0]        o_char_position,
    output logic [PROB_W-1:0]         o_mean_confidence,
    output logic [TOTAL_W-1:0]        o_char_total,
    output logic                      o_last
);

    logic [CLASS_W-1:0]        r_charset;
    logic signed [LOGIT_W-1:0] r_best_score;
    logic [CLASS_W-1:0]        r_best_class;
    logic [CC_W-1:0]           r_cc;
    logic                      r_step_full;
    logic [CLASS_W-1:0]        r_prev;
    logic [SUM_W-1:0]          r_sum;
    logic [TOTAL_W-1:0]        r_count;
    logic [STEP_W-1:0]         r_step_cnt;

    // exp unit
    logic signed [LOGIT_W:0] r_n;
    logic [31:0]             r_r, r_b;
    logic                    r_r_one;

    // divider
    logic [DIV_W-1:0]   r_quo;
    logic [TOTAL_W-1:0] r_rem;

    // output register
    logic                 r_o_valid, r_o_kind, r_o_last;
    logic [CLASS_W-1:0]   r_o_pos;
    logic [PROB_W-1:0]    r_o_mean;
    logic [TOTAL_W-1:0]   r_o_total;

    logic                    step_open;
    logic                    take;
    logic [CC_W:0]           cc_next;
    logic [3:0]              bit_idx;
    logic [EXP_BITS-1:0]     n_bits;
    logic                    phase;
    logic [31:0]             mul_a;
    logic [63:0]             prod;
    logic [31:0]             mul_rnd;
    logic [32:0]             rnd_prob;
    logic [PROB_W-1:0]       prob;
    logic [SUM_W:0]          sum_add;
    logic [DIV_W-1:0]        dividend;
    logic [TOTAL_W+1:0]      trial;
    logic [PROB_W-1:0]       mean;

    assign step_open = r_step_cnt < STEP_W'(MAX_STEPS);
    assign take      = i_cmd.accept && !r_step_full
                       && (r_cc == '0 || i_logit > r_best_score);
    assign cc_next   = {1'b0, r_cc} + 1'b1;

    assign o_sts.char_hit = step_open && r_best_class != '0 && r_best_class != r_prev
                            && r_best_class <= r_charset;
    assign o_sts.out_free = !r_o_valid || i_ready;

    // one shared multiplier: even passes r*b, odd passes b*b
    assign bit_idx = i_cmd.iter[4:1];
    assign n_bits  = r_n[EXP_BITS-1:0];
    assign phase   = i_cmd.iter[0];
    assign mul_a   = phase ? r_b : r_r;
    assign prod    = 64'(mul_a) * 64'(r_b);
    assign mul_rnd = 32'((prod + 64'h8000_0000) >> 32);

    always_comb begin
        rnd_prob = ({1'b0, r_r} + 33'h8000) >> 16;
        if (r_n[LOGIT_W] || r_n == '0) begin
            prob = PROB_MAX;
        end else if (r_n >= (LOGIT_W + 1)'(1 << EXP_BITS)) begin
            prob = '0;
        end else if (r_r_one || rnd_prob[16]) begin
            prob = PROB_MAX;
        end else begin
            prob = rnd_prob[PROB_W-1:0];
        end
    end

    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(prob);
    assign dividend = DIV_W'(r_sum) + DIV_W'(r_count >> 1);
    assign trial    = {1'b0, r_rem, r_quo[DIV_W-1]} - {2'b0, r_count};

    always_comb begin
        if (r_count == '0) begin
            mean = '0;
        end else if (r_quo[DIV_W-1:PROB_W] != '0) begin
            mean = PROB_MAX;
        end else begin
            mean = r_quo[PROB_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset    <= CLASS_W'(MAX_CLASSES - 1);
            r_best_score <= '0;
            r_best_class <= '0;
            r_cc         <= '0;
            r_step_full  <= 1'b0;
            r_prev       <= '0;
            r_sum        <= '0;
            r_count      <= '0;
            r_step_cnt   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_charset <= i_cfg_data;
            end
            if (take) begin
                r_best_score <= i_logit;
                r_best_class <= CLASS_W'(r_cc);
            end
            if (i_cmd.accept && !r_step_full) begin
                if (cc_next >= (CC_W + 1)'(MAX_CLASSES)) begin
                    r_step_full <= 1'b1;
                end else begin
                    r_cc <= cc_next[CC_W-1:0];
                end
            end
            if (i_cmd.eval) begin
                r_cc        <= '0;
                r_step_full <= 1'b0;
                if (step_open) begin
                    r_step_cnt <= r_step_cnt + 1'b1;
                    r_prev     <= r_best_class;
                end
            end
            if (i_cmd.emit_char) begin
                r_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.emit_sum) begin
                r_sum      <= '0;
                r_count    <= '0;
                r_prev     <= '0;
                r_step_cnt <= '0;
            end
            if (i_cmd.emit_char || i_cmd.emit_sum) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // exp iteration, divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_n     <= -{r_best_score[LOGIT_W-1], r_best_score};
            r_r     <= '0;
            r_r_one <= 1'b1;
            r_b     <= EXP_STEP_Q32;
        end
        if (i_cmd.exp_step) begin
            if (phase) begin
                r_b <= mul_rnd;
            end else if (n_bits[bit_idx]) begin
                r_r     <= r_r_one ? r_b : mul_rnd;
                r_r_one <= 1'b0;
            end
        end
        if (i_cmd.div_init) begin
            r_quo <= dividend;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (!trial[TOTAL_W+1]) begin
                r_rem <= trial[TOTAL_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[TOTAL_W-2:0], r_quo[DIV_W-1]};
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit_char) begin
            r_o_kind  <= KIND_CHAR;
            r_o_pos   <= r_best_class - 1'b1;
            r_o_mean  <= '0;
            r_o_total <= '0;
            r_o_last  <= !i_cmd.seq_end;
        end
        if (i_cmd.emit_sum) begin
            r_o_kind  <= KIND_SUMMARY;
            r_o_pos   <= '0;
            r_o_mean  <= mean;
            r_o_total <= r_count;
            r_o_last  <= 1'b1;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_char_position   = r_o_pos;
    assign o_mean_confidence = r_o_mean;
    assign o_char_total      = r_o_total;
    assign o_last            = r_o_last;

endmodule

[tb/sv/tb_ctc_greedy_decode_confidence.sv]
module tb_ctc_greedy_decode_confidence;
    import ctcgd_pkg::*;

    // clock period in time units, guard times in cycles
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = 64;          // guard after the last result for any internal work left
    localparam int LIMIT_CYCLES = 3_000_000;   // watchdog, many times the slowest correct run

    // exp(-1/256) in Q0.32, one LSB of a Q8.8 log score
    localparam bit [63:0] EXP_NEG_LSB   = 64'd4278222805;
    localparam int        PROB_SAT      = 65535;
    localparam int        SUM_SAT       = 33554431;
    localparam int        COUNT_SAT     = 511;
    localparam int        REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                kind;
        logic [CLASS_W-1:0]  position;
        logic [PROB_W-1:0]   mean;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } t_decode_result;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [CLASS_W-1:0]        i_cfg_data     = '0;
    logic                      i_valid        = 1'b0;
    logic                      o_ready;
    logic signed [LOGIT_W-1:0] i_logit        = '0;
    logic                      i_last_in_step = 1'b0;
    logic                      i_last_step    = 1'b0;
    logic                      o_valid;
    logic                      i_ready        = 1'b1;
    logic                      o_kind;
    logic [CLASS_W-1:0]        o_char_position;
    logic [PROB_W-1:0]         o_mean_confidence;
    logic [TOTAL_W-1:0]        o_char_total;
    logic                      o_last;

    ctc_greedy_decode_confidence dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_logit           (i_logit),
        .i_last_in_step    (i_last_in_step),
        .i_last_step       (i_last_step),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_char_position   (o_char_position),
        .o_mean_confidence (o_mean_confidence),
        .o_char_total      (o_char_total),
        .o_last            (o_last)
    );

    // results the decoder owes us, oldest first
    t_decode_result decoded_q[$];

    // idle controls for the sender and the receiver, plus item and failure counts
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_cycles = 0;
    int items_sent  = 0;
    int failures    = 0;

    // shadow of the decoder state
    logic [CLASS_W-1:0]        charset_size;
    logic signed [LOGIT_W-1:0] best_score;
    logic [CLASS_W-1:0]        best_class;
    int                        class_count;
    bit                        step_full;
    logic [CLASS_W-1:0]        prev_class;
    int                        prob_sum;
    int                        emit_count;
    int                        step_total;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Q8.8 log score to Q0.16 probability, square-and-multiply over the 12 magnitude bits
    function automatic int exp_q16(input logic signed [LOGIT_W-1:0] score);
        int        mag;
        bit [63:0] acc;
        bit [63:0] base;
        bit [63:0] rounded;
        mag = -int'(score);
        if (mag <= 0) return PROB_SAT;
        if (mag >= 4096) return 0;
        acc  = 64'd1 << 32;
        base = EXP_NEG_LSB;
        for (int k = 0; k < 12; k++) begin
            if (mag[k]) acc = (acc * base + 64'h8000_0000) >> 32;
            base = (base * base + 64'h8000_0000) >> 32;
        end
        rounded = (acc + 64'd32768) >> 16;
        return (rounded > PROB_SAT) ? PROB_SAT : int'(rounded);
    endfunction

    task automatic clear_sequence_shadow();
        prev_class = '0;
        prob_sum   = 0;
        emit_count = 0;
        step_total = 0;
    endtask

    // append one owed result at the tail
    task automatic owe_result(input logic kind, input logic [CLASS_W-1:0] position,
                              input logic [PROB_W-1:0] mean, input logic [TOTAL_W-1:0] total,
                              input logic last);
        t_decode_result res;
        res.kind     = kind;
        res.position = position;
        res.mean     = mean;
        res.total    = total;
        res.last     = last;
        decoded_q.insert(decoded_q.size(), res);
    endtask

    // one accepted logit: track the argmax, close the step and the sequence
    task automatic greedy_decode(input logic signed [LOGIT_W-1:0] logit,
                                 input logic end_of_step, input logic end_of_seq);
        logic [CLASS_W-1:0] cls;
        bit                 hit;
        int                 quot;
        hit = 0;
        if (!step_full) begin
            // first maximum wins: strictly greater only
            if (class_count == 0 || logit > best_score) begin
                best_score = logit;
                best_class = class_count[CLASS_W-1:0];
            end
            if (class_count + 1 >= MAX_CLASSES) step_full = 1;
            else class_count++;
        end
        if (!end_of_step) return;
        cls = best_class;
        // steps past the limit neither emit nor move the previous class
        if (step_total < MAX_STEPS) begin
            step_total++;
            if (cls != 0 && cls != prev_class && cls <= charset_size) begin
                prob_sum += exp_q16(best_score);
                if (prob_sum > SUM_SAT) prob_sum = SUM_SAT;
                if (emit_count < COUNT_SAT) emit_count++;
                hit = 1;
            end
            prev_class = cls;
        end
        class_count = 0;
        step_full   = 0;
        if (hit) owe_result(KIND_CHAR, cls - 1'b1, '0, '0, !end_of_seq);
        if (end_of_seq) begin
            quot = 0;
            if (emit_count != 0) begin
                quot = (prob_sum + emit_count / 2) / emit_count;
                if (quot > PROB_SAT) quot = PROB_SAT;
            end
            owe_result(KIND_SUMMARY, '0, PROB_W'(quot), TOTAL_W'(emit_count), 1'b1);
            clear_sequence_shadow();
        end
    endtask

    // offer one item, hold it until taken, then predict
    task automatic send_logit(input logic signed [LOGIT_W-1:0] logit,
                              input logic end_of_step, input logic end_of_seq);
        bit idle;
        idle = 1;
        while (idle) begin
            @(negedge i_clk);
            idle = ($urandom_range(0, 99) < idle_pct);
            if (idle) i_valid <= 1'b0;
        end
        i_valid        <= 1'b1;
        i_logit        <= logit;
        i_last_in_step <= end_of_step;
        i_last_step    <= end_of_seq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        greedy_decode(logit, end_of_step, end_of_seq);
        items_sent++;
    endtask

    // sender stops until every owed result is out, then waits a settle time
    task automatic wait_all_decoded();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_charset(input int size);
        wait_all_decoded();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CLASS_W'(size);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        charset_size = CLASS_W'(size);
    endtask

    // well-formed sequence: per step a chosen winner, near-ties, repeats and blanks
    task automatic send_sequence(input int steps, input int max_cls);
        int ncls;
        int target;
        int prev_target;
        int tval;
        int v;
        prev_target = 0;
        for (int s = 0; s < steps; s++) begin
            ncls = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 131)
                                                : $urandom_range(1, max_cls);
            case ($urandom_range(0, 3))
                0:       target = prev_target;
                1:       target = 0;
                default: target = $urandom_range(0, ncls - 1);
            endcase
            tval = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3000))
                                               : -int'($urandom_range(0, 4300));
            for (int c = 0; c < ncls; c++) begin
                if ($urandom_range(0, 15) == 0)
                    v = int'($signed(16'($urandom)));
                else if (c == target || $urandom_range(0, 7) == 0)
                    v = tval;
                else
                    v = tval - int'($urandom_range(1, 3000));
                if (v < -32768) v = -32768;
                // end marks on inner classes must be ignored
                send_logit(16'(v), c == ncls - 1,
                           (c == ncls - 1) ? (s == steps - 1) : ($urandom_range(0, 7) == 0));
            end
            prev_target = target;
        end
    endtask

    // raw items with random marks, partial steps included
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_logit(16'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    endtask

    // extremes of the score, blank wins, repeats, ties and an empty sequence
    task automatic test_directed_basics();
        send_logit(-16'sd32768, 0, 0);
        send_logit(16'sd32767,  1, 0);   // saturated probability
        send_logit(16'sd0,      0, 0);
        send_logit(-16'sd1,     0, 1);
        send_logit(16'sd0,      1, 0);   // tie with blank, blank wins
        send_logit(-16'sd4096,  0, 0);
        send_logit(-16'sd4095,  0, 0);
        send_logit(-16'sd4097,  1, 0);   // deepest nonzero probability
        send_logit(-16'sd5000,  0, 1);
        send_logit(-16'sd4096,  1, 0);   // repeat of the previous class
        send_logit(-16'sd20000, 0, 0);
        send_logit(-16'sd30000, 0, 0);
        send_logit(-16'sd4096,  1, 1);   // probability floors at zero
        send_logit(16'sd100,    1, 1);   // nothing emitted, mean is zero
        send_logit(-16'sd300,   0, 0);
        send_logit(-16'sd1,     1, 1);
        wait_all_decoded();
    endtask

    // classes past the 128th are dropped; class 127, the top class, is emitted at charset size 127, not at 126
    task automatic test_class_overflow();
        for (int pass = 0; pass < 2; pass++) begin
            write_charset(pass == 0 ? 127 : 126);
            for (int c = 0; c < 130; c++)
                send_logit(c < 127 ? -16'sd1000 : (c == 127 ? -16'sd10 : 16'sd32767),
                           c == 129, c == 129);
        end
        wait_all_decoded();
    endtask

    // more steps than the limit: class 1 and blank alternate, steps past the 256th are silent
    task automatic test_step_overflow();
        write_charset(127);
        for (int s = 0; s < MAX_STEPS + 4; s++) begin
            send_logit(s % 2 ? -16'sd10 : -16'sd8000, 0, 0);
            send_logit(s % 2 ? -16'sd8000 : -16'(int'($urandom_range(0, 600))), 1,
                       s == MAX_STEPS + 3);
        end
        wait_all_decoded();
    endtask

    // charset extremes and a few sizes in between
    task automatic test_charset_sweep();
        int sizes[6] = '{0, 1, 2, 5, 126, 127};
        foreach (sizes[i]) begin
            write_charset(sizes[i]);
            send_sequence(3, 8);
        end
        wait_all_decoded();
    endtask

    // receiver shuts off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        hold_cycles = 800;
        for (int s = 0; s < 30; s++) begin
            send_logit(-16'sd3000, 0, 0);
            send_logit(s % 2 ? -16'sd10 : -16'sd2000, 0, 0);
            send_logit(s % 2 ? -16'sd2000 : -16'sd10, 1, s == 29);
        end
        wait_all_decoded();
    endtask

    // bulk random traffic under one idle setting
    task automatic test_random_phase(input int send_idle, input int recv_stall, input int count);
        int start;
        case ($urandom_range(0, 5))
            0:       write_charset(0);
            1:       write_charset(127);
            2:       write_charset($urandom_range(0, 127));
            default: write_charset($urandom_range(1, 9));
        endcase
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        start     = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 12));
            else send_sequence($urandom_range(1, 12), $urandom_range(2, 10));
        end
        wait_all_decoded();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result checker: every taken result against the oldest owed one
    initial begin
        t_decode_result want;
        t_decode_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_kind, o_char_position, o_mean_confidence, o_char_total, o_last};
                if (decoded_q.size() == 0) begin
                    if (failures < REPORT_LIMIT)
                        $display("unexpected result: kind=%0d pos=%0d mean=%0d total=%0d last=%0d",
                                 got.kind, got.position, got.mean, got.total, got.last);
                    failures++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.mean !== want.mean || got.total !== want.total ||
                        got.last !== want.last) begin
                        if (failures < REPORT_LIMIT) begin
                            $write("mismatch: expected kind=%0d pos=%0d mean=%0d total=%0d",
                                   want.kind, want.position, want.mean, want.total);
                            $display(" last=%0d, got kind=%0d pos=%0d mean=%0d total=%0d last=%0d",
                                     want.last, got.kind, got.position, got.mean, got.total,
                                     got.last);
                        end
                        failures++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        // shadow state matches the decoder after reset
        charset_size = 7'd127;
        best_score   = '0;
        best_class   = '0;
        class_count  = 0;
        step_full    = 0;
        clear_sequence_shadow();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_class_overflow();
        test_step_overflow();
        test_charset_sweep();
        test_output_backpressure();
        test_random_phase(0, 0, 60);
        test_random_phase(82, 0, 60);
        test_random_phase(0, 82, 60);
        test_random_phase(22, 22, 60);

        wait_all_decoded();
        if (failures == 0 && decoded_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[ctc_greedy_decode_confidence.f]
+incdir+rtl/core
rtl/core/ctcgd_pkg.sv
rtl/core/ctcgd_ctrl.sv
rtl/core/ctcgd_dp.sv
rtl/core/ctc_greedy_decode_confidence.sv
tb/sv/tb_ctc_greedy_decode_confidence.sv
